// ===== src/lru_replacement_tracker_assert.svh =====
// Assertion macros shared by the LRU replacement tracker modules.
// Each macro expects a signal named clock and an active-high reset in scope.
`ifndef LRU_REPLACEMENT_TRACKER_ASSERT_SVH
`define LRU_REPLACEMENT_TRACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRT_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lru tracker assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LRT_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lru tracker assertion failed");

`endif

// ===== src/lrt_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the
// LRU replacement tracker. No dependencies.
`timescale 1ns / 1ps

package lrt_pkg;

   localparam int ENTRIES       = 16;
   localparam int KEY_BITS      = 16;
   localparam int KEY_PORT_BITS = 16;
   localparam int STORE_BITS    = (KEY_BITS < KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;
   localparam int COUNT_BITS    = $clog2(ENTRIES + 1);
   localparam int IDX_BITS      = $clog2(ENTRIES);

   localparam logic [COUNT_BITS-1:0] ENTRIES_CNT = COUNT_BITS'(ENTRIES);

   typedef enum logic [1:0] {
      OP_TOUCH  = 2'd0,
      OP_VICTIM = 2'd1,
      OP_ERASE  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_MOVE   = 2'd1,
      ACT_APPEND = 2'd2,
      ACT_REMOVE = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_MATCH = 3'b010,
      S_APPLY = 3'b100
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       match;
      logic       apply;
      action_type action;
      status_type status;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   found;
      logic   full;
   } stat_type;

endpackage

// ===== src/lrt_datapath.sv =====
// Datapath of the LRU replacement tracker: the recency-ordered key slots,
// the parallel key match and the shift/insert update. Depends on lrt_pkg.
`timescale 1ns / 1ps
`include "lru_replacement_tracker_assert.svh"

module lrt_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [1:0]                        req_operation,
   input  logic [lrt_pkg::KEY_PORT_BITS-1:0] req_key,
   input  lrt_pkg::cmd_type                  cmd,
   output lrt_pkg::stat_type                 stat,
   output logic [1:0]                        rsp_status,
   output logic [lrt_pkg::KEY_PORT_BITS-1:0] rsp_victim_key,
   output logic [lrt_pkg::COUNT_BITS-1:0]    rsp_entry_count
);

   lrt_pkg::op_type                    op_ff;
   logic [lrt_pkg::STORE_BITS-1:0]     key_ff;
   logic [lrt_pkg::STORE_BITS-1:0]     slot_ff [lrt_pkg::ENTRIES];
   logic [lrt_pkg::STORE_BITS-1:0]     slot_in [lrt_pkg::ENTRIES];
   logic [lrt_pkg::STORE_BITS-1:0]     slot_up [lrt_pkg::ENTRIES];
   logic [lrt_pkg::COUNT_BITS-1:0]     count_ff;
   logic [lrt_pkg::COUNT_BITS-1:0]     count_in;
   logic [lrt_pkg::ENTRIES-1:0]        sel_in;
   logic [lrt_pkg::ENTRIES-1:0]        ge_ff;
   logic [lrt_pkg::ENTRIES-1:0]        ge_in;
   logic                               found_ff;
   logic [lrt_pkg::IDX_BITS-1:0]       wpos;
   logic                               shift_en;
   logic                               write_en;
   logic [1:0]                         status_ff;
   logic [lrt_pkg::KEY_PORT_BITS-1:0]  victim_ff;
   logic [lrt_pkg::KEY_PORT_BITS-1:0]  victim_in;
   logic [lrt_pkg::COUNT_BITS-1:0]     rsp_count_ff;

   genvar g;
   generate
      for (g = 0; g < lrt_pkg::ENTRIES; g++) begin : g_up
         if (g == lrt_pkg::ENTRIES - 1) begin : g_last
            assign slot_up[g] = slot_ff[g];
         end else begin : g_mid
            assign slot_up[g] = slot_ff[g + 1];
         end
      end
   endgenerate

   always_comb begin
      for (int i = 0; i < lrt_pkg::ENTRIES; i++) begin
         if (op_ff == lrt_pkg::OP_VICTIM) begin
            sel_in[i] = (i == 0) && (count_ff != '0);
         end else begin
            sel_in[i] = (lrt_pkg::COUNT_BITS'(i) < count_ff) && (slot_ff[i] == key_ff);
         end
      end
      for (int i = 0; i < lrt_pkg::ENTRIES; i++) begin
         ge_in[i] = |(sel_in & ({lrt_pkg::ENTRIES{1'b1}} >> (lrt_pkg::ENTRIES - 1 - i)));
      end
   end

   always_comb begin
      shift_en = (cmd.action == lrt_pkg::ACT_MOVE) || (cmd.action == lrt_pkg::ACT_REMOVE);
      write_en = (cmd.action == lrt_pkg::ACT_MOVE) || (cmd.action == lrt_pkg::ACT_APPEND);
      if (cmd.action == lrt_pkg::ACT_MOVE) begin
         wpos = lrt_pkg::IDX_BITS'(count_ff - 1'b1);
      end else begin
         wpos = lrt_pkg::IDX_BITS'(count_ff);
      end
      for (int i = 0; i < lrt_pkg::ENTRIES; i++) begin
         slot_in[i] = slot_ff[i];
         if (shift_en && ge_ff[i]) begin
            slot_in[i] = slot_up[i];
         end
         if (write_en && (lrt_pkg::IDX_BITS'(i) == wpos)) begin
            slot_in[i] = key_ff;
         end
      end
      case (cmd.action)
         lrt_pkg::ACT_APPEND: count_in = count_ff + 1'b1;
         lrt_pkg::ACT_REMOVE: count_in = count_ff - 1'b1;
         default:             count_in = count_ff;
      endcase
      if ((op_ff == lrt_pkg::OP_VICTIM) && (cmd.action == lrt_pkg::ACT_REMOVE)) begin
         victim_in = lrt_pkg::KEY_PORT_BITS'(slot_ff[0]);
      end else begin
         victim_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.apply) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= lrt_pkg::op_type'(req_operation);
         key_ff <= req_key[lrt_pkg::STORE_BITS-1:0];
      end
      if (cmd.match) begin
         ge_ff    <= ge_in;
         found_ff <= |sel_in;
      end
      if (cmd.apply) begin
         slot_ff      <= slot_in;
         status_ff    <= cmd.status;
         victim_ff    <= victim_in;
         rsp_count_ff <= count_in;
      end
   end

   assign stat.op         = op_ff;
   assign stat.found      = found_ff;
   assign stat.full       = (count_ff == lrt_pkg::ENTRIES_CNT);
   assign rsp_status      = status_ff;
   assign rsp_victim_key  = victim_ff;
   assign rsp_entry_count = rsp_count_ff;

   `LRT_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= lrt_pkg::ENTRIES_CNT)
   `LRT_ASSERT_SAME(a_remove_needs_hit, cmd.apply && (cmd.action == lrt_pkg::ACT_REMOVE), found_ff)

endmodule

// ===== src/lrt_ctrl.sv =====
// Controller of the LRU replacement tracker: request sequencing, choice of
// the update action and status, and the result strobe. Depends on lrt_pkg.
`timescale 1ns / 1ps
`include "lru_replacement_tracker_assert.svh"

module lrt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_strobe,
   output lrt_pkg::cmd_type  cmd,
   input  lrt_pkg::stat_type stat
);

   lrt_pkg::state_type state_ff;
   lrt_pkg::state_type state_in;
   logic               rsp_strobe_ff;
   logic               rsp_strobe_in;

   always_comb begin
      state_in      = state_ff;
      rsp_strobe_in = 1'b0;
      cmd.capture   = 1'b0;
      cmd.match     = 1'b0;
      cmd.apply     = 1'b0;
      cmd.action    = lrt_pkg::ACT_NONE;
      cmd.status    = lrt_pkg::ST_MISS;
      unique case (state_ff)
         lrt_pkg::S_IDLE: begin
            cmd.capture = start;
            if (start) begin
               state_in = lrt_pkg::S_MATCH;
            end
         end
         lrt_pkg::S_MATCH: begin
            cmd.match = 1'b1;
            state_in  = lrt_pkg::S_APPLY;
         end
         lrt_pkg::S_APPLY: begin
            cmd.apply     = 1'b1;
            rsp_strobe_in = 1'b1;
            state_in      = lrt_pkg::S_IDLE;
            unique case (stat.op) inside
               lrt_pkg::OP_TOUCH: begin
                  if (stat.found) begin
                     cmd.action = lrt_pkg::ACT_MOVE;
                     cmd.status = lrt_pkg::ST_DONE;
                  end else if (!stat.full) begin
                     cmd.action = lrt_pkg::ACT_APPEND;
                     cmd.status = lrt_pkg::ST_DONE;
                  end else begin
                     cmd.status = lrt_pkg::ST_FULL;
                  end
               end
               lrt_pkg::OP_VICTIM, lrt_pkg::OP_ERASE: begin
                  if (stat.found) begin
                     cmd.action = lrt_pkg::ACT_REMOVE;
                     cmd.status = lrt_pkg::ST_DONE;
                  end
               end
               default: begin
                  cmd.action = lrt_pkg::ACT_NONE;
               end
            endcase
         end
         default: begin
            state_in = lrt_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lrt_pkg::S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign busy       = (state_ff != lrt_pkg::S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;

   `LRT_ASSERT_NEXT(a_accept_to_match, start && !busy, state_ff == lrt_pkg::S_MATCH)
   `LRT_ASSERT_NEXT(a_apply_to_strobe, state_ff == lrt_pkg::S_APPLY, rsp_strobe_ff)
   `LRT_ASSERT_SAME(a_strobe_when_idle, rsp_strobe_ff, state_ff == lrt_pkg::S_IDLE)

endmodule

// ===== src/lru_replacement_tracker.sv =====
// Top level of the LRU replacement tracker: joins the controller and the
// datapath. Depends on lrt_pkg, lrt_ctrl and lrt_datapath.
//
// Usage:
// The tracker holds up to ENTRIES distinct keys ordered from least to most
// recently used. A request (req_operation, req_key) is taken at a rising edge
// where start is high and busy is low. Operation touch moves a key to the
// most-recent end or appends it if the tracker is not full, victim removes
// and returns the least-recent key, and erase removes a key if present.
// Each request yields one result on rsp_status, rsp_victim_key and
// rsp_entry_count, valid for the single cycle in which rsp_strobe is high.
// After the accepting edge the request passes the match state, which registers
// the parallel key compare, and then the apply state, which does the slot shift
// and insert and registers the result onto the ports. No new request is taken
// while busy, in the match and apply states; busy falls in the result cycle, so
// the next request may be accepted while the result is shown.
// Reset empties the tracker and returns the controller to idle; slot
// contents are not cleared because only slots below the count are read.
// The receiver cannot stall; every result must be taken in its strobe cycle.
`timescale 1ns / 1ps

module lru_replacement_tracker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_operation,
   input  logic [lrt_pkg::KEY_PORT_BITS-1:0] req_key,
   output logic                              rsp_strobe,
   output logic [1:0]                        rsp_status,
   output logic [lrt_pkg::KEY_PORT_BITS-1:0] rsp_victim_key,
   output logic [lrt_pkg::COUNT_BITS-1:0]    rsp_entry_count
);

   lrt_pkg::cmd_type  cmd;
   lrt_pkg::stat_type stat;

   lrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   lrt_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_operation   (req_operation),
      .req_key         (req_key),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_status      (rsp_status),
      .rsp_victim_key  (rsp_victim_key),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

// ===== test/lru_replacement_tracker_tb.sv =====
// Self-checking testbench for the LRU replacement tracker: a directed table, then
// random request streams under three sender idling profiles, all scored in order.
// Depends on lrt_pkg and lru_replacement_tracker.
`timescale 1ns / 1ps

module lru_replacement_tracker_tb;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int         PHASE_ITEMS = 650;
   localparam int         POOL_SIZE = 24;

   typedef struct packed {
      lrt_pkg::status_type                status;
      logic [lrt_pkg::KEY_PORT_BITS-1:0]  victim_key;
      logic [lrt_pkg::COUNT_BITS-1:0]     entry_count;
   } tracker_rsp_type;

   typedef struct packed {
      logic [1:0]                         op;
      logic [lrt_pkg::KEY_PORT_BITS-1:0]  key;
      logic                               typed;
      tracker_rsp_type                    result;
   } stim_row_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 start;
   logic                                 busy;
   logic [1:0]                           req_operation;
   logic [lrt_pkg::KEY_PORT_BITS-1:0]    req_key;
   logic                                 rsp_strobe;
   logic [1:0]                           rsp_status;
   logic [lrt_pkg::KEY_PORT_BITS-1:0]    rsp_victim_key;
   logic [lrt_pkg::COUNT_BITS-1:0]       rsp_entry_count;

   logic                                 req_typed;
   tracker_rsp_type                      req_typed_result;

   logic [lrt_pkg::KEY_PORT_BITS-1:0]    order_keys [lrt_pkg::ENTRIES];
   int                                   order_count;
   tracker_rsp_type                      lru_results_due [$];
   tracker_rsp_type                      oldest_due;
   stim_row_type                         stim_rows [$];
   logic [lrt_pkg::KEY_PORT_BITS-1:0]    key_pool [POOL_SIZE];

   int error_count;
   int checked_count;
   int refused_count;
   int victim_count;
   int miss_count;
   int gap_pct;
   int touch_pct;
   int drain_cycles;

   lru_replacement_tracker u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_key         (req_key),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_victim_key  (rsp_victim_key),
      .rsp_entry_count (rsp_entry_count)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic void drop_slot(input int idx);
      for (int i = idx; i + 1 < order_count; i++) begin
         order_keys[i] = order_keys[i + 1];
      end
      order_count--;
   endfunction

   function automatic tracker_rsp_type lru_apply(input logic [1:0] op,
                                                 input logic [lrt_pkg::KEY_PORT_BITS-1:0] key);
      tracker_rsp_type r;
      int              pos;
      r.status = lrt_pkg::ST_MISS;
      r.victim_key = '0;
      pos = -1;
      for (int i = 0; i < order_count; i++) begin
         if (pos < 0 && order_keys[i] == key) pos = i;
      end
      case (op)
         lrt_pkg::OP_TOUCH: begin
            if (pos >= 0) begin
               drop_slot(pos);
               order_keys[order_count] = key;
               order_count++;
               r.status = lrt_pkg::ST_DONE;
            end else if (order_count < lrt_pkg::ENTRIES) begin
               order_keys[order_count] = key;
               order_count++;
               r.status = lrt_pkg::ST_DONE;
            end else begin
               r.status = lrt_pkg::ST_FULL;
            end
         end
         lrt_pkg::OP_VICTIM: begin
            if (order_count > 0) begin
               r.victim_key = order_keys[0];
               drop_slot(0);
               r.status = lrt_pkg::ST_DONE;
            end
         end
         lrt_pkg::OP_ERASE: begin
            if (pos >= 0) begin
               drop_slot(pos);
               r.status = lrt_pkg::ST_DONE;
            end
         end
         default: begin
         end
      endcase
      r.entry_count = lrt_pkg::COUNT_BITS'(order_count);
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (lru_results_due.size() == 0) begin
               $error("unexpected result: status %0d victim_key %h entry_count %0d",
                      rsp_status, rsp_victim_key, rsp_entry_count);
               error_count++;
            end else begin
               oldest_due = lru_results_due.pop_front();
               checked_count++;
               if (rsp_status !== oldest_due.status) begin
                  $error("status: expected %0d, actual %0d", oldest_due.status, rsp_status);
                  error_count++;
               end
               if (rsp_victim_key !== oldest_due.victim_key) begin
                  $error("victim_key: expected %h, actual %h",
                         oldest_due.victim_key, rsp_victim_key);
                  error_count++;
               end
               if (rsp_entry_count !== oldest_due.entry_count) begin
                  $error("entry_count: expected %0d, actual %0d",
                         oldest_due.entry_count, rsp_entry_count);
                  error_count++;
               end
               if (oldest_due.status == lrt_pkg::ST_FULL) refused_count++;
               if (oldest_due.status == lrt_pkg::ST_MISS) miss_count++;
               if (oldest_due.status == lrt_pkg::ST_DONE && rsp_victim_key !== '0) begin
                  victim_count++;
               end
            end
         end
         if (start && !busy) begin
            if (req_typed) begin
               void'(lru_apply(req_operation, req_key));
               lru_results_due.push_back(req_typed_result);
            end else begin
               lru_results_due.push_back(lru_apply(req_operation, req_key));
            end
         end
      end
   end

   task automatic add_row(input logic [1:0] op, input logic [lrt_pkg::KEY_PORT_BITS-1:0] key,
                          input logic typed, input lrt_pkg::status_type st,
                          input logic [lrt_pkg::KEY_PORT_BITS-1:0] victim, input int count);
      stim_row_type row;
      row.op = op;
      row.key = key;
      row.typed = typed;
      row.result.status = st;
      row.result.victim_key = victim;
      row.result.entry_count = lrt_pkg::COUNT_BITS'(count);
      stim_rows.push_back(row);
   endtask

   task automatic issue_request(input logic [1:0] op,
                                input logic [lrt_pkg::KEY_PORT_BITS-1:0] key,
                                input logic typed, input tracker_rsp_type result);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_operation = op;
      req_key = key;
      req_typed = typed;
      req_typed_result = result;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [lrt_pkg::KEY_PORT_BITS-1:0] pick_key();
      if ($urandom_range(99) < 80) return key_pool[$urandom_range(POOL_SIZE - 1)];
      return lrt_pkg::KEY_PORT_BITS'($urandom_range(16'hFFFF));
   endfunction

   function automatic logic [1:0] pick_op();
      int roll;
      roll = $urandom_range(99);
      if (roll < touch_pct) return lrt_pkg::OP_TOUCH;
      if (roll < touch_pct + (95 - touch_pct) / 3) return lrt_pkg::OP_VICTIM;
      if (roll < 95) return lrt_pkg::OP_ERASE;
      return OP_UNUSED;
   endfunction

   initial begin
      #5_000_000;
      $display("lru_replacement_tracker_tb NOT OK");
      $finish;
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_operation = lrt_pkg::OP_TOUCH;
      req_key = '0;
      req_typed = 1'b0;
      req_typed_result = '0;
      order_count = 0;
      error_count = 0;
      checked_count = 0;
      refused_count = 0;
      victim_count = 0;
      miss_count = 0;
      gap_pct = 0;
      touch_pct = 50;
      for (int i = 0; i < lrt_pkg::ENTRIES; i++) order_keys[i] = '0;

      add_row(lrt_pkg::OP_VICTIM, 16'h0000, 1'b1, lrt_pkg::ST_MISS, 16'h0000, 0);
      add_row(lrt_pkg::OP_ERASE, 16'h1234, 1'b1, lrt_pkg::ST_MISS, 16'h0000, 0);
      add_row(OP_UNUSED, 16'hFFFF, 1'b1, lrt_pkg::ST_MISS, 16'h0000, 0);
      add_row(lrt_pkg::OP_TOUCH, 16'h0000, 1'b1, lrt_pkg::ST_DONE, 16'h0000, 1);
      add_row(lrt_pkg::OP_TOUCH, 16'hFFFF, 1'b1, lrt_pkg::ST_DONE, 16'h0000, 2);
      add_row(lrt_pkg::OP_TOUCH, 16'h0000, 1'b0, lrt_pkg::ST_DONE, 16'h0000, 0);
      add_row(lrt_pkg::OP_VICTIM, 16'hA5A5, 1'b0, lrt_pkg::ST_DONE, 16'h0000, 0);
      for (int i = 0; i < 15; i++) begin
         add_row(lrt_pkg::OP_TOUCH, lrt_pkg::KEY_PORT_BITS'(16'h0001 << i), 1'b0,
                 lrt_pkg::ST_DONE, 16'h0000, 0);
      end
      add_row(lrt_pkg::OP_TOUCH, 16'h8000, 1'b1, lrt_pkg::ST_FULL, 16'h0000,
              lrt_pkg::ENTRIES);
      add_row(lrt_pkg::OP_TOUCH, 16'h0000, 1'b0, lrt_pkg::ST_DONE, 16'h0000, 0);
      add_row(lrt_pkg::OP_ERASE, 16'h0100, 1'b0, lrt_pkg::ST_DONE, 16'h0000, 0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (stim_rows[i]) begin
         issue_request(stim_rows[i].op, stim_rows[i].key, stim_rows[i].typed,
                       stim_rows[i].result);
      end

      for (int phase = 0; phase < 3; phase++) begin
         gap_pct = (phase == 0) ? 8 : (phase == 1) ? 79 : 0;
         key_pool[0] = 16'h0000;
         key_pool[1] = 16'hFFFF;
         for (int i = 2; i < POOL_SIZE; i++) begin
            key_pool[i] = lrt_pkg::KEY_PORT_BITS'($urandom_range(16'hFFFF));
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 50 == 0) touch_pct = $urandom_range(30, 75);
            issue_request(pick_op(), pick_key(), 1'b0, '0);
         end
      end

      @(negedge clock);
      start = 1'b0;
      drain_cycles = 0;
      while (lru_results_due.size() > 0 && drain_cycles < 1000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (10) @(posedge clock);
      if (lru_results_due.size() > 0) begin
         $error("%0d results never arrived", lru_results_due.size());
         error_count++;
      end

      $display("Scored %0d results with three sender idling profiles.", checked_count);
      $display("Seen: %0d victims taken, %0d misses, %0d inserts refused on a full tracker.",
               victim_count, miss_count, refused_count);
      if (error_count == 0) begin
         $display("lru_replacement_tracker_tb OK");
      end else begin
         $display("lru_replacement_tracker_tb NOT OK");
      end
      $finish;
   end

endmodule
